>>> rtl/core/sdsch_pkg.sv
`timescale 1ns / 1ps

package sdsch_pkg;

  // Default number of request slots in the sorting chain.
  localparam int QUEUE_DEPTH_DEF = 32;

  localparam int CYL_W      = 16;
  localparam int DIST_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_HEAD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREVIOUS_HEAD = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CYL_W-1:0] DISK_SIZE_RST     = 16'd200;
  localparam logic [CYL_W-1:0] CURRENT_HEAD_RST  = 16'd1;
  localparam logic [CYL_W-1:0] PREVIOUS_HEAD_RST = 16'd0;

  // One input item.
  typedef struct packed {
    logic [CYL_W-1:0] request_cylinder;
    logic             last_request;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [CYL_W-1:0]  position;
    logic              at_boundary;
    logic [DIST_W-1:0] total_distance;
    logic              last_result;
    logic              error;
  } out_item_t;

  // Per-cell control from the chain to each sorting cell.
  typedef struct packed {
    logic ins_en;
    logic occupied;
    logic at_tail;
  } cell_ctl_t;

endpackage

>>> rtl/core/sdsch_cell.sv
`timescale 1ns / 1ps

module sdsch_cell (
  input  logic                      clk,
  input  sdsch_pkg::cell_ctl_t      ctl,
  input  logic [sdsch_pkg::CYL_W-1:0] ins_val,
  input  logic [sdsch_pkg::CYL_W-1:0] left_data,
  input  logic                      left_gt,
  output logic [sdsch_pkg::CYL_W-1:0] data_o,
  output logic                      gt_o
);
  import sdsch_pkg::*;

  logic [CYL_W-1:0] data_r;
  logic [CYL_W-1:0] data_nxt;
  logic             shift;

  // A held value larger than the new request makes room for it.
  assign gt_o  = ctl.occupied && (data_r > ins_val);
  assign shift = ctl.ins_en && (gt_o || ctl.at_tail);

  // Take the left neighbor's value if it also moves, else the new request.
  assign data_nxt = left_gt ? left_data : ins_val;

  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= data_nxt;
    end
  end

  assign data_o = data_r;

endmodule

>>> rtl/core/sdsch_chain.sv
`timescale 1ns / 1ps

module sdsch_chain #(
  parameter int QUEUE_DEPTH = sdsch_pkg::QUEUE_DEPTH_DEF,
  parameter int IW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        ins_en,
  input  logic [sdsch_pkg::CYL_W-1:0] ins_val,
  input  logic [CW-1:0]               count,
  input  logic [IW-1:0]               rd_idx,
  output logic [sdsch_pkg::CYL_W-1:0] rd_data,
  output logic [sdsch_pkg::CYL_W-1:0] head_data
);
  import sdsch_pkg::*;

  logic [CYL_W-1:0] cell_data [QUEUE_DEPTH];
  logic             cell_gt   [QUEUE_DEPTH];

  // Row of insertion cells, kept in ascending order.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctl_t        ctl;
    logic [CYL_W-1:0] left_data;
    logic             left_gt;

    assign ctl.ins_en   = ins_en;
    assign ctl.occupied = CW'(i) < count;
    assign ctl.at_tail  = CW'(i) == count;

    if (i == 0) begin : g_first
      assign left_data = ins_val;
      assign left_gt   = 1'b0;
    end else begin : g_rest
      assign left_data = cell_data[i-1];
      assign left_gt   = cell_gt[i-1];
    end

    sdsch_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .ins_val   (ins_val),
      .left_data (left_data),
      .left_gt   (left_gt),
      .data_o    (cell_data[i]),
      .gt_o      (cell_gt[i])
    );
  end

  // Single read port for the scan and service phases.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (rd_idx == IW'(i)) begin
        rd_data = cell_data[i];
      end
    end
  end

  // The smallest request always sits in the first cell.
  assign head_data = cell_data[0];

endmodule

>>> rtl/core/scan_disk_scheduler_unit.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready  | in_item_t (request_cylinder, last_request)
// out_    | output    | out_valid / out_ready| out_item_t (position .. error)
// cfg_    | input     | cfg_we               | cfg_idx, cfg_wdata
//
// Requests are taken one per cycle while in_ready is high; each one in range, with
// room left, lands in the insertion chain in that cycle. After the last request a
// scan of the chain finds the split at the head, one cell per cycle, then N+1
// results follow at one per cycle while out_ready allows, save at the turn to the
// boundary; a rejected batch gets its single error item from the error state.
// Reset is synchronous and active low; it empties the queue and the output register.
// in_ready is low from the last request until the final result has been loaded;
// a stalled out_ready holds the output register and pauses the service sequence.

module scan_disk_scheduler_unit #(
  parameter int QUEUE_DEPTH = sdsch_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sdsch_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sdsch_pkg::out_item_t             out_data,
  input  logic                             cfg_we,
  input  logic [sdsch_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sdsch_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sdsch_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_EMIT1 = 6'b000100,
    S_BND   = 6'b001000,
    S_EMIT2 = 6'b010000,
    S_ERR   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              err_r, err_nxt;
  logic [CYL_W-1:0]  max_r, max_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     below_r, below_nxt;
  logic              down_r, down_nxt;
  logic [DIST_W-1:0] total_r, total_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic [CYL_W-1:0]  size_r, head_r, prev_r;

  logic              accept;
  logic              req_bad;
  logic              ovf;
  logic              ins_en;
  logic              head_bad;
  logic              run_desc;
  logic              run_left;
  logic              emit_ok;
  logic              emit;
  out_item_t         emit_item;
  logic [CW-1:0]     rd_idx_w;
  logic [CYL_W-1:0]  rd_data;
  logic [CYL_W-1:0]  min_data;
  logic [DIST_W-1:0] dist_up_far;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= DISK_SIZE_RST;
      head_r <= CURRENT_HEAD_RST;
      prev_r <= PREVIOUS_HEAD_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DISK_SIZE:     size_r <= cfg_wdata;
        CFG_CURRENT_HEAD:  head_r <= cfg_wdata;
        CFG_PREVIOUS_HEAD: prev_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request checks.
  assign accept   = in_valid && in_ready;
  assign req_bad  = (in_data.request_cylinder == '0) || (in_data.request_cylinder >= size_r);
  assign ovf      = count_r >= CW'(QUEUE_DEPTH);
  assign ins_en   = accept && !req_bad && !ovf;
  assign head_bad = (head_r == '0) || (head_r >= size_r) ||
                    (prev_r == '0) || (prev_r >= size_r);

  // Service runs: descending reads below the pointer, ascending reads at it.
  assign run_desc = ((state_r == S_EMIT1) && down_r) || ((state_r == S_EMIT2) && !down_r);
  assign run_left = run_desc ? (ptr_r != '0) : (ptr_r != count_r);
  assign rd_idx_w = run_desc ? (ptr_r - CW'(1)) : ptr_r;
  assign emit_ok  = !out_valid_r || out_ready;

  sdsch_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IW          (IW),
    .CW          (CW)
  ) u_chain (
    .clk       (clk),
    .ins_en    (ins_en),
    .ins_val   (in_data.request_cylinder),
    .count     (count_r),
    .rd_idx    (rd_idx_w[IW-1:0]),
    .rd_data   (rd_data),
    .head_data (min_data)
  );

  // Far-side travel when moving up with requests below the head.
  assign dist_up_far = (ptr_r != '0) ? {1'b0, size_r - min_data} : '0;

  // Sequencer for loading, scanning and service order.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    max_nxt   = max_r;
    ptr_nxt   = ptr_r;
    below_nxt = below_r;
    down_nxt  = down_r;
    total_nxt = total_r;
    emit      = 1'b0;
    emit_item = '0;

    case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (ins_en) begin
            count_nxt = count_r + CW'(1);
            if ((count_r == '0) || (in_data.request_cylinder > max_r)) begin
              max_nxt = in_data.request_cylinder;
            end
          end
          err_nxt = err_r || !ins_en;
          if (in_data.last_request) begin
            ptr_nxt   = '0;
            state_nxt = (err_nxt || head_bad) ? S_ERR : S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if ((ptr_r != count_r) && (rd_data < head_r)) begin
          ptr_nxt = ptr_r + CW'(1);
        end else begin
          below_nxt = ptr_r;
          down_nxt  = head_r < prev_r;
          if (head_r < prev_r) begin
            total_nxt = (ptr_r != count_r) ? ({1'b0, head_r} + {1'b0, max_r})
                                           : {1'b0, head_r};
          end else begin
            total_nxt = {1'b0, size_r - head_r} + dist_up_far;
          end
          state_nxt = S_EMIT1;
        end
      end

      S_EMIT1: begin
        if (run_left) begin
          if (emit_ok) begin
            emit               = 1'b1;
            emit_item.position = rd_data;
            ptr_nxt            = run_desc ? (ptr_r - CW'(1)) : (ptr_r + CW'(1));
          end
        end else begin
          ptr_nxt   = below_r;
          state_nxt = S_BND;
        end
      end

      S_BND: begin
        if (emit_ok) begin
          emit                  = 1'b1;
          emit_item.position    = down_r ? '0 : size_r;
          emit_item.at_boundary = 1'b1;
          if (down_r ? (below_r == count_r) : (below_r == '0)) begin
            emit_item.last_result    = 1'b1;
            emit_item.total_distance = total_r;
            state_nxt = S_LOAD;
            count_nxt = '0;
            err_nxt   = 1'b0;
          end else begin
            state_nxt = S_EMIT2;
          end
        end
      end

      S_EMIT2: begin
        if (!run_left) begin
          state_nxt = S_LOAD;
          count_nxt = '0;
          err_nxt   = 1'b0;
        end else if (emit_ok) begin
          emit               = 1'b1;
          emit_item.position = rd_data;
          ptr_nxt            = run_desc ? (ptr_r - CW'(1)) : (ptr_r + CW'(1));
          if (run_desc ? (ptr_r == CW'(1)) : ((ptr_r + CW'(1)) == count_r)) begin
            emit_item.last_result    = 1'b1;
            emit_item.total_distance = total_r;
            state_nxt = S_LOAD;
            count_nxt = '0;
            err_nxt   = 1'b0;
          end
        end
      end

      S_ERR: begin
        if (emit_ok) begin
          emit                  = 1'b1;
          emit_item.last_result = 1'b1;
          emit_item.error       = 1'b1;
          state_nxt = S_LOAD;
          count_nxt = '0;
          err_nxt   = 1'b0;
        end
      end

      default: begin
        state_nxt = S_LOAD;
        count_nxt = '0;
        err_nxt   = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    max_r   <= max_nxt;
    ptr_r   <= ptr_nxt;
    below_r <= below_nxt;
    down_r  <= down_nxt;
    total_r <= total_nxt;
    if (emit) begin
      out_data_r <= emit_item;
    end
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/sdsch_checker.sv
`timescale 1ns / 1ps

module sdsch_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input sdsch_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input sdsch_pkg::out_item_t out_data
);
  import sdsch_pkg::*;

  // The output register is empty after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A rejected batch gives one final item with a zero position.
  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.last_result && (out_data.position == '0))
    else $error("error item is not a final item");

  // Travel is reported only on the final item.
  a_dist_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |-> out_data.total_distance == '0)
    else $error("travel on a non-final item");

  // Input closes once the last request of a batch has been taken.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_request |=> !in_ready)
    else $error("input open right after last request");

endmodule

bind scan_disk_scheduler_unit sdsch_checker u_sdsch_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> sim/tb_scan_disk_scheduler_unit.sv
`timescale 1ns / 1ps

module tb_scan_disk_scheduler_unit;
  import sdsch_pkg::*;

  localparam int QDEPTH         = QUEUE_DEPTH_DEF;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 65;
  localparam int SHOWN_ERRORS   = 10;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow of the configuration registers and of the pending batch.
  logic [CYL_W-1:0] disk_sz;
  logic [CYL_W-1:0] cur_head;
  logic [CYL_W-1:0] prev_head;
  logic [CYL_W-1:0] pend_cyl [QDEPTH];
  int               pend_count;
  bit               batch_bad;

  // Service order still owed by the block, oldest first.
  out_item_t service_q[$];

  int fail_count   = 0;
  int items_sent   = 0;
  int idle_cycles  = 0;
  bit steady_flow  = 1'b0;
  bit rx_hold_req  = 1'b0;
  int rx_hold_left = 0;
  int rx_gap_left  = 0;

  scan_disk_scheduler_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // 100 MHz clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic out_item_t visit(input logic [CYL_W-1:0] pos, input logic bnd);
    out_item_t res;
    res = '0;
    res.position = pos;
    res.at_boundary = bnd;
    return res;
  endfunction

  // Absorb one request into the sorted batch; on the last request, queue the
  // whole SCAN service order (or the single rejection item).
  function automatic void absorb_request(input in_item_t item);
    int below;
    int slot;
    int travel;
    out_item_t svc[$];
    out_item_t res;
    if (item.request_cylinder < 16'd1 || item.request_cylinder >= disk_sz) begin
      batch_bad = 1'b1;
    end else if (pend_count >= QDEPTH) begin
      batch_bad = 1'b1;
    end else begin
      slot = pend_count;
      while (slot > 0 && pend_cyl[slot-1] > item.request_cylinder) begin
        pend_cyl[slot] = pend_cyl[slot-1];
        slot--;
      end
      pend_cyl[slot] = item.request_cylinder;
      pend_count++;
    end
    if (!item.last_request) return;

    if (cur_head < 16'd1 || cur_head >= disk_sz || prev_head < 16'd1 || prev_head >= disk_sz)
      batch_bad = 1'b1;

    if (batch_bad) begin
      res = '0;
      res.last_result = 1'b1;
      res.error = 1'b1;
      service_q.push_back(res);
    end else begin
      // Requests below the head form the lower side; equal counts as upper.
      below = 0;
      while (below < pend_count && pend_cyl[below] < cur_head) below++;
      if (cur_head < prev_head) begin
        travel = (below < pend_count) ? cur_head + pend_cyl[pend_count-1] : cur_head;
        for (slot = below; slot > 0; slot--) svc.push_back(visit(pend_cyl[slot-1], 1'b0));
        svc.push_back(visit('0, 1'b1));
        for (slot = below; slot < pend_count; slot++) svc.push_back(visit(pend_cyl[slot], 1'b0));
      end else begin
        travel = disk_sz - cur_head;
        if (below > 0) travel += disk_sz - pend_cyl[0];
        for (slot = below; slot < pend_count; slot++) svc.push_back(visit(pend_cyl[slot], 1'b0));
        svc.push_back(visit(disk_sz, 1'b1));
        for (slot = below; slot > 0; slot--) svc.push_back(visit(pend_cyl[slot-1], 1'b0));
      end
      res = svc.pop_back();
      res.total_distance = DIST_W'(travel);
      res.last_result = 1'b1;
      svc.push_back(res);
      foreach (svc[i]) service_q.push_back(svc[i]);
    end
    pend_count = 0;
    batch_bad = 1'b0;
  endfunction

  // Offer one item after an optional gap and hold it until it is taken.
  task automatic send_item(input logic [CYL_W-1:0] cyl, input logic last);
    int gap;
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.request_cylinder = cyl;
    in_data.last_request = last;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_request(in_data);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop sending and let every owed result drain before touching registers.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (service_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_DISK_SIZE:     disk_sz = val;
      CFG_CURRENT_HEAD:  cur_head = val;
      CFG_PREVIOUS_HEAD: prev_head = val;
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [15:0] size, input logic [15:0] cur,
                              input logic [15:0] prev);
    wait_idle();
    write_reg(CFG_DISK_SIZE, size);
    write_reg(CFG_CURRENT_HEAD, cur);
    write_reg(CFG_PREVIOUS_HEAD, prev);
  endtask

  // Out of reset the previous head is zero, so any batch is rejected.
  task automatic test_reset_defaults();
    send_item(16'd50, 1'b1);
  endtask

  // Moving up, with a request on the head, the lowest and the highest cylinder.
  task automatic test_scan_upward();
    set_geometry(16'd200, 16'd50, 16'd40);
    write_reg(CFG_IDX_SPARE, 16'hFFFF);
    send_item(16'd120, 1'b0);
    send_item(16'd10, 1'b0);
    send_item(16'd50, 1'b0);
    send_item(16'd199, 1'b0);
    send_item(16'd1, 1'b1);
  endtask

  // Moving down; a request on the head is served after the boundary.
  task automatic test_scan_downward();
    set_geometry(16'd200, 16'd50, 16'd60);
    send_item(16'd49, 1'b0);
    send_item(16'd80, 1'b0);
    send_item(16'd20, 1'b0);
    send_item(16'd50, 1'b1);
  endtask

  // All requests on one side of the head, in both directions.
  task automatic test_one_sided();
    send_item(16'd70, 1'b1);
    set_geometry(16'd200, 16'd150, 16'd100);
    send_item(16'd10, 1'b1);
  endtask

  // Requests outside 1..size-1 poison the batch.
  task automatic test_bad_request();
    send_item(16'd0, 1'b0);
    send_item(16'd200, 1'b0);
    send_item(16'd100, 1'b1);
    send_item(16'hFFFF, 1'b1);
  endtask

  // Head registers out of range reject the batch at its last request.
  task automatic test_bad_head();
    set_geometry(16'd200, 16'd0, 16'd100);
    send_item(16'd30, 1'b1);
    set_geometry(16'd200, 16'd200, 16'd100);
    send_item(16'd30, 1'b1);
    set_geometry(16'd200, 16'd100, 16'd200);
    send_item(16'd30, 1'b1);
  endtask

  // Smallest and largest disks, and one too small to hold any request.
  task automatic test_size_extremes();
    set_geometry(16'd2, 16'd1, 16'd1);
    send_item(16'd1, 1'b1);
    set_geometry(16'd65535, 16'd32768, 16'd1);
    send_item(16'd65534, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd40000, 1'b1);
    set_geometry(16'd1, 16'd1, 16'd1);
    send_item(16'd1, 1'b1);
  endtask

  // Two requests beyond the queue depth overflow; a full queue yields the most results.
  task automatic test_queue_overflow();
    int k;
    set_geometry(16'd1000, 16'd500, 16'd400);
    for (k = 0; k <= QDEPTH + 1; k++) send_item(16'($urandom_range(1, 999)), k == QDEPTH + 1);
    for (k = 0; k < QDEPTH; k++) send_item(16'($urandom_range(1, 999)), k == QDEPTH - 1);
  endtask

  // Receiver holds off while batches keep coming, then the sender drains.
  task automatic test_backpressure();
    int k;
    set_geometry(16'd500, 16'd250, 16'd100);
    rx_hold_req = 1'b1;
    steady_flow = 1'b1;
    for (k = 0; k < 8; k++) send_item(16'($urandom_range(1, 499)), k == 7);
    for (k = 0; k < 6; k++) send_item(16'($urandom_range(1, 499)), k == 5);
    steady_flow = 1'b0;
    in_valid = 1'b0;
    while (service_q.size() != 0) @(posedge clk);
    @(negedge clk);
    for (k = 0; k < 3; k++) send_item(16'($urandom_range(1, 499)), k == 2);
  endtask

  function automatic logic [CYL_W-1:0] rand_cylinder();
    int r;
    if (disk_sz < 16'd2) return 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 59);
    case (r)
      0: return 16'd0;
      1: return 16'($urandom_range(disk_sz, 65535));
      2: return cur_head;
      3: return disk_sz - 16'd1;
      4: return 16'd1;
      default: return 16'($urandom_range(1, disk_sz - 1));
    endcase
  endfunction

  function automatic logic [CYL_W-1:0] rand_head();
    if (disk_sz >= 16'd2 && $urandom_range(0, 9) != 0)
      return 16'($urandom_range(1, disk_sz - 1));
    return ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
  endfunction

  function automatic int pick_batch_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 20);
    if (r < 97) return $urandom_range(21, QDEPTH);
    return $urandom_range(QDEPTH + 1, QDEPTH + 8);
  endfunction

  // Random geometry per phase, then a few batches with random content.
  task automatic test_random_traffic();
    int first;
    int nbatch;
    int blen;
    int r;
    int b;
    int k;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      wait_idle();
      steady_flow = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 19);
      if (r == 0) write_reg(CFG_DISK_SIZE, 16'd2);
      else if (r == 1) write_reg(CFG_DISK_SIZE, 16'd65535);
      else if (r == 2) write_reg(CFG_DISK_SIZE, 16'($urandom_range(0, 1)));
      else if (r < 10) write_reg(CFG_DISK_SIZE, 16'($urandom_range(3, 64)));
      else if (r < 17) write_reg(CFG_DISK_SIZE, 16'($urandom_range(65, 65535)));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_CURRENT_HEAD, rand_head());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_PREVIOUS_HEAD, rand_head());
      nbatch = $urandom_range(1, 4);
      for (b = 0; b < nbatch; b++) begin
        blen = pick_batch_len();
        for (k = 0; k < blen; k++) send_item(rand_cylinder(), k == blen - 1);
      end
    end
    steady_flow = 1'b0;
  endtask

  // Result side: random stalls, a long hold on request, none in steady phases.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_left = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (rx_hold_left > 0) begin
        out_ready = 1'b0;
        rx_hold_left--;
      end else if (rx_gap_left > 0) begin
        out_ready = 1'b0;
        rx_gap_left--;
      end else if (!steady_flow && $urandom_range(0, 2) == 0) begin
        rx_gap_left = pick_gap();
        out_ready = (rx_gap_left == 0);
        if (rx_gap_left > 0) rx_gap_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Compare each taken result with the oldest one owed.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (service_q.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOWN_ERRORS)
          $display("unexpected result: pos=%0d bnd=%0b dist=%0d last=%0b err=%0b",
                   out_data.position, out_data.at_boundary, out_data.total_distance,
                   out_data.last_result, out_data.error);
      end else begin
        want = service_q.pop_front();
        if (out_data.position !== want.position ||
            out_data.at_boundary !== want.at_boundary ||
            out_data.total_distance !== want.total_distance ||
            out_data.last_result !== want.last_result ||
            out_data.error !== want.error) begin
          fail_count++;
          if (fail_count <= SHOWN_ERRORS)
            $display("mismatch: expected pos=%0d bnd=%0b dist=%0d last=%0b err=%0b,",
                     want.position, want.at_boundary, want.total_distance,
                     want.last_result, want.error,
                     " got pos=%0d bnd=%0b dist=%0d last=%0b err=%0b",
                     out_data.position, out_data.at_boundary, out_data.total_distance,
                     out_data.last_result, out_data.error);
        end
      end
    end
  end

  // End the run if no item moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Reset, then the tests in turn, then drain and report.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_DISK_SIZE;
    cfg_wdata = '0;
    disk_sz = DISK_SIZE_RST;
    cur_head = CURRENT_HEAD_RST;
    prev_head = PREVIOUS_HEAD_RST;
    pend_count = 0;
    batch_bad = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_scan_upward();
    test_scan_downward();
    test_one_sided();
    test_bad_request();
    test_bad_head();
    test_size_extremes();
    test_queue_overflow();
    test_backpressure();
    test_random_traffic();

    in_valid = 1'b0;
    while (service_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && service_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sdsch_pkg.sv
rtl/core/sdsch_cell.sv
rtl/core/sdsch_chain.sv
rtl/core/scan_disk_scheduler_unit.sv
rtl/core/sdsch_checker.sv
sim/tb_scan_disk_scheduler_unit.sv
